>>> rtl/core/qdf_pkg.sv
package qdf_pkg;

  // sample and result widths
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DERIV_BITS  = SAMPLE_BITS + 3;
  localparam int unsigned DELTA_BITS  = SAMPLE_BITS + 4;
  localparam int unsigned FEAT_BITS   = SAMPLE_BITS + 4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DERIV_BITS-1:0]  deriv_t;
  typedef logic signed [DELTA_BITS-1:0]  delta_t;
  typedef logic        [FEAT_BITS-1:0]   feat_t;

  // command queue between front and back
  localparam int unsigned CMD_DEPTH    = 4;
  localparam int unsigned CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);
  localparam logic [CMD_CNT_BITS-1:0] CMD_FULL = CMD_CNT_BITS'(CMD_DEPTH);

  // result queue at the output
  localparam int unsigned OUT_DEPTH    = 2;
  localparam int unsigned OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);
  localparam logic [OUT_CNT_BITS-1:0] OUT_FULL = OUT_CNT_BITS'(OUT_DEPTH);

  // window fill and end-of-record flush
  localparam logic [1:0] SEEN_FULL   = 2'd2;
  localparam logic [1:0] FLUSH_STEPS = 2'd2;
  localparam logic [1:0] FLUSH_FINAL = 2'd1;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LAST   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    sample_t   sample;
    cmd_kind_e kind;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

>>> rtl/core/qdf_front.sv
module qdf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  qdf_pkg::sample_t    sample_i,
  input  logic                last_i,
  output qdf_pkg::cmd_chan_t  cmd_o,
  input  logic                cmd_pop_i
);

  qdf_pkg::cmd_t                       mem_q [qdf_pkg::CMD_DEPTH];
  logic [qdf_pkg::CMD_PTR_BITS-1:0]    wr_ptr_q;
  logic [qdf_pkg::CMD_PTR_BITS-1:0]    rd_ptr_q;
  logic [qdf_pkg::CMD_CNT_BITS-1:0]    cnt_q;
  logic [qdf_pkg::CMD_CNT_BITS-1:0]    cnt_d;
  logic                                wr_en;
  logic                                rd_en;
  qdf_pkg::cmd_t                       cmd_in;

  // classify the request: plain sample or end of record
  always_comb begin
    cmd_in.sample = sample_i;
    cmd_in.kind   = last_i ? qdf_pkg::CMD_LAST : qdf_pkg::CMD_SAMPLE;
  end

  assign full  = (cnt_q == qdf_pkg::CMD_FULL);
  assign wr_en = push && !full;
  assign rd_en = cmd_pop_i && (cnt_q != '0);

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

endmodule

>>> rtl/core/qdf_back.sv
module qdf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qdf_pkg::cmd_chan_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output qdf_pkg::deriv_t     derivative_o,
  output qdf_pkg::feat_t      feature_o,
  output logic                end_of_run_o
);

  // window state
  qdf_pkg::sample_t hist_q [4];
  logic [1:0]       seen_q;
  logic             first_q;
  logic [1:0]       flush_cnt_q;

  // derivative stage
  logic             a_valid_q;
  qdf_pkg::deriv_t  a_deriv_q;
  logic             a_has_prev_q;
  logic             a_end_q;
  qdf_pkg::deriv_t  prev_q;

  // result queue
  qdf_pkg::deriv_t                  out_deriv_q [qdf_pkg::OUT_DEPTH];
  qdf_pkg::feat_t                   out_feat_q  [qdf_pkg::OUT_DEPTH];
  logic                             out_end_q   [qdf_pkg::OUT_DEPTH];
  logic [qdf_pkg::OUT_PTR_BITS-1:0] out_wr_q;
  logic [qdf_pkg::OUT_PTR_BITS-1:0] out_rd_q;
  logic [qdf_pkg::OUT_CNT_BITS-1:0] out_cnt_q;
  logic [qdf_pkg::OUT_CNT_BITS-1:0] out_cnt_d;

  logic             flushing;
  logic             is_final;
  logic             produce;
  logic             b_adv;
  logic             a_free;
  logic             step;
  logic             out_rd;
  qdf_pkg::sample_t s;
  qdf_pkg::deriv_t  deriv;
  qdf_pkg::delta_t  d_wide;
  qdf_pkg::delta_t  delta;
  qdf_pkg::delta_t  d_abs;
  qdf_pkg::delta_t  delta_abs;
  qdf_pkg::feat_t   feature;

  // step control: a flush zero goes ahead of the next queued request
  assign flushing  = (flush_cnt_q != '0);
  assign is_final  = (flush_cnt_q == qdf_pkg::FLUSH_FINAL);
  assign produce   = (seen_q == qdf_pkg::SEEN_FULL);
  assign b_adv     = a_valid_q && (out_cnt_q != qdf_pkg::OUT_FULL);
  assign a_free    = !a_valid_q || b_adv;
  assign step      = (flushing || cmd_i.valid) && a_free;
  assign cmd_pop_o = step && !flushing;
  assign s         = flushing ? '0 : cmd_i.cmd.sample;

  // five-point centre derivative, scaled by eight
  assign deriv = (qdf_pkg::deriv_t'(hist_q[0]) <<< 1) + qdf_pkg::deriv_t'(s)
               - qdf_pkg::deriv_t'(hist_q[3]) - (qdf_pkg::deriv_t'(hist_q[2]) <<< 1);

  // window history and record bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
      seen_q      <= '0;
      first_q     <= 1'b0;
      flush_cnt_q <= '0;
    end else if (step) begin
      if (is_final) begin
        for (int i = 0; i < 4; i++) begin
          hist_q[i] <= '0;
        end
        seen_q      <= '0;
        first_q     <= 1'b0;
        flush_cnt_q <= '0;
      end else begin
        hist_q[3] <= hist_q[2];
        hist_q[2] <= hist_q[1];
        hist_q[1] <= hist_q[0];
        hist_q[0] <= s;
        if (!produce) begin
          seen_q <= seen_q + 1'b1;
        end
        if (produce) begin
          first_q <= 1'b1;
        end
        if (flushing) begin
          flush_cnt_q <= flush_cnt_q - 1'b1;
        end else if (cmd_i.cmd.kind == qdf_pkg::CMD_LAST) begin
          flush_cnt_q <= qdf_pkg::FLUSH_STEPS;
        end
      end
    end
  end

  // derivative stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (step) begin
      a_valid_q <= produce;
    end else if (b_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  // derivative stage payload and previous derivative
  always_ff @(posedge clk_i) begin
    if (step && produce) begin
      a_deriv_q    <= deriv;
      a_has_prev_q <= first_q;
      a_end_q      <= is_final;
    end
    if (b_adv) begin
      prev_q <= a_deriv_q;
    end
  end

  // feature: |D| + |D - previous D|
  always_comb begin
    d_wide    = qdf_pkg::delta_t'(a_deriv_q);
    delta     = a_has_prev_q ? (d_wide - qdf_pkg::delta_t'(prev_q)) : '0;
    d_abs     = d_wide[qdf_pkg::DELTA_BITS-1] ? -d_wide : d_wide;
    delta_abs = delta[qdf_pkg::DELTA_BITS-1] ? -delta : delta;
    feature   = qdf_pkg::feat_t'(d_abs) + qdf_pkg::feat_t'(delta_abs);
  end

  // result queue control
  assign out_rd = pop && (out_cnt_q != '0);

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (b_adv && !out_rd) begin
      out_cnt_d = out_cnt_q + 1'b1;
    end else if (out_rd && !b_adv) begin
      out_cnt_d = out_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (b_adv) begin
        out_wr_q <= out_wr_q + 1'b1;
      end
      if (out_rd) begin
        out_rd_q <= out_rd_q + 1'b1;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_deriv_q[out_wr_q] <= a_deriv_q;
      out_feat_q[out_wr_q]  <= feature;
      out_end_q[out_wr_q]   <= a_end_q;
    end
  end

  assign empty        = (out_cnt_q == '0);
  assign derivative_o = out_deriv_q[out_rd_q];
  assign feature_o    = out_feat_q[out_rd_q];
  assign end_of_run_o = out_end_q[out_rd_q];

`ifndef SYNTHESIS
  // queued requests are never taken while flush zeros are pending
  a_no_pop_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !flushing)
    else $error("request taken during flush");

  // the last flush step always completes a window
  a_final_produces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && is_final) |-> produce)
    else $error("final flush step without result");

  // record state is back at reset after the final result
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && is_final) |=> (seen_q == '0 && !first_q && flush_cnt_q == '0
                            && a_valid_q && a_end_q))
    else $error("record state not cleared after final result");
`endif

endmodule

>>> rtl/core/qrs_derivative_feature.sv
// Five-point centre derivative and QRS feature over an ECG record.
// Input channel: drive sample_i and last_i with push; a request is taken on
// a rising edge with push high and full low. last_i marks the record's final
// sample. Result channel: while empty is low the oldest result sits on
// derivative_o, feature_o and end_of_run_o; it is taken on an edge with pop
// high. derivative_o is eight times the derivative, feature_o eight times
// |D| + |D - previous D|, end_of_run_o flags the record's last result.
// Results lag by two samples: the first two samples of a record give none,
// the final sample releases up to three, the last one flagged.
// Each result is held in the derivative stage, then in the result queue.
// One sample per cycle is sustained while the result queue has room and no
// flush runs; the final sample of a record adds two zero flush steps to the
// derivative stage while a four-entry request queue keeps taking input.
// If pop stays low, a two-entry result queue fills, the derivative stage
// holds, and the request queue raises full when its four entries are used.
// Reset empties both queues and clears the sample window.
module qrs_derivative_feature (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  qdf_pkg::sample_t  sample_i,
  input  logic              last_i,
  output logic              empty,
  input  logic              pop,
  output qdf_pkg::deriv_t   derivative_o,
  output qdf_pkg::feat_t    feature_o,
  output logic              end_of_run_o
);

  qdf_pkg::cmd_chan_t cmd;
  logic               cmd_pop;

  // request intake and queue
  qdf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .sample_i  (sample_i),
    .last_i    (last_i),
    .cmd_o     (cmd),
    .cmd_pop_i (cmd_pop)
  );

  // derivative, feature and result queue
  qdf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .derivative_o (derivative_o),
    .feature_o    (feature_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule
